// File: design/signed_decimal_ascii_writer_macros.svh
// ----------------------------------------------------------------------------
// Signed decimal ASCII writer - assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_ASCII_WRITER_MACROS_SVH
`define SIGNED_DECIMAL_ASCII_WRITER_MACROS_SVH

// same-cycle implication
`define SDAW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDAW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sdaw_pkg.sv
// ----------------------------------------------------------------------------
// Signed decimal ASCII writer - package
// Constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sdaw_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 6;
    localparam int MAX_DIGITS  = 10;
    localparam int BCD_W       = 4 * MAX_DIGITS;
    localparam int CNT_W       = $clog2(VALUE_W);
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_NINE  = CHAR_W'(57);

    typedef struct packed {
        logic load;
        logic shift;
        logic locate;
        logic emit_sign;
        logic emit_digit;
    } sdaw_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic negative;
        logic slot_free;
        logic last_digit;
    } sdaw_sts_t;

endpackage

// File: design/sdaw_dp.sv
// ----------------------------------------------------------------------------
// Signed decimal ASCII writer - datapath
// Magnitude, shift-add-3 BCD conversion, digit pointer and output register.
// ----------------------------------------------------------------------------
`include "signed_decimal_ascii_writer_macros.svh"

module sdaw_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic signed [sdaw_pkg::VALUE_W-1:0] s_value,
    input  sdaw_pkg::sdaw_cmd_t               cmd,
    output sdaw_pkg::sdaw_sts_t               sts,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sdaw_pkg::CHAR_W-1:0]       m_character,
    output logic                              m_last
);

    logic [sdaw_pkg::VALUE_W-1:0]     mag_reg,  mag_next;
    logic [sdaw_pkg::BCD_W-1:0]       bcd_reg,  bcd_next;
    logic [sdaw_pkg::CNT_W-1:0]       cnt_reg,  cnt_next;
    logic [sdaw_pkg::DIGIT_IDX_W-1:0] idx_reg,  idx_next;
    logic                             neg_reg,  neg_next;
    logic                             valid_reg, valid_next;
    logic [sdaw_pkg::CHAR_W-1:0]      char_reg, char_next;
    logic                             last_reg, last_next;

    logic [sdaw_pkg::BCD_W-1:0]       bcd_adj;
    logic [sdaw_pkg::DIGIT_IDX_W-1:0] top_idx;
    logic [3:0]                       cur_digit;
    logic [sdaw_pkg::VALUE_W-1:0]     value_u;

    assign value_u   = sdaw_pkg::VALUE_W'(s_value);
    assign cur_digit = bcd_reg[idx_reg*4 +: 4];

    always_comb begin
        for (int i = 0; i < sdaw_pkg::MAX_DIGITS; i++) begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                             : bcd_reg[i*4 +: 4];
        end
    end

    // highest nonzero digit, zero when all digits are zero
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < sdaw_pkg::MAX_DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] != 4'd0) begin
                top_idx = sdaw_pkg::DIGIT_IDX_W'(i);
            end
        end
    end

    always_comb begin
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (cmd.load) begin
            neg_next = value_u[sdaw_pkg::VALUE_W-1];
            mag_next = value_u[sdaw_pkg::VALUE_W-1] ? (~value_u + 1'b1) : value_u;
            bcd_next = '0;
            cnt_next = '0;
        end
        if (cmd.shift) begin
            bcd_next = {bcd_adj[sdaw_pkg::BCD_W-2:0], mag_reg[sdaw_pkg::VALUE_W-1]};
            mag_next = {mag_reg[sdaw_pkg::VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.locate) begin
            idx_next = top_idx;
        end
        if (cmd.emit_sign) begin
            valid_next = 1'b1;
            char_next  = sdaw_pkg::CHAR_MINUS;
            last_next  = 1'b0;
        end
        if (cmd.emit_digit) begin
            valid_next = 1'b1;
            char_next  = sdaw_pkg::CHAR_ZERO + sdaw_pkg::CHAR_W'(cur_digit);
            last_next  = (idx_reg == '0);
            idx_next   = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign sts.conv_last  = (cnt_reg == sdaw_pkg::CNT_W'(sdaw_pkg::VALUE_W - 1));
    assign sts.negative   = neg_reg;
    assign sts.slot_free  = !valid_reg || m_ready;
    assign sts.last_digit = (idx_reg == '0);

    assign m_valid     = valid_reg;
    assign m_character = char_reg;
    assign m_last      = last_reg;

    `SDAW_ASSERT_NOW(a_minus_not_last, m_valid && (m_character == sdaw_pkg::CHAR_MINUS), !m_last, "minus sign marked last")
    `SDAW_ASSERT_NOW(a_digit_range, m_valid && (m_character != sdaw_pkg::CHAR_MINUS), (m_character >= sdaw_pkg::CHAR_ZERO) && (m_character <= sdaw_pkg::CHAR_NINE), "character out of range")
    `SDAW_ASSERT_NEXT(a_final_digit, cmd.emit_digit && (idx_reg == '0), m_valid && m_last, "final digit not marked last")
    `SDAW_ASSERT_NEXT(a_locate_nonzero, cmd.locate, (idx_reg == '0) || (cur_digit != 4'd0), "leading digit is zero")

endmodule

// File: design/sdaw_ctrl.sv
// ----------------------------------------------------------------------------
// Signed decimal ASCII writer - controller
// Sequences load, 32 conversion shifts, digit location and character output.
// ----------------------------------------------------------------------------
module sdaw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sdaw_pkg::sdaw_sts_t sts,
    output sdaw_pkg::sdaw_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOCATE,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.shift = 1'b1;
                if (sts.conv_last) begin
                    state_next = ST_LOCATE;
                end
            end
            ST_LOCATE: begin
                cmd.locate = 1'b1;
                state_next = sts.negative ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (sts.slot_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (sts.slot_free) begin
                    cmd.emit_digit = 1'b1;
                    if (sts.last_digit) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// File: design/signed_decimal_ascii_writer.sv
// ----------------------------------------------------------------------------
// Signed decimal ASCII writer
// Converts a signed 32-bit integer to its decimal text, one character per
// result request, minus sign first, leading zeros suppressed.
//
//   channel  | ports                          | role
//   ---------+--------------------------------+-----------------------------
//   s_       | s_valid s_ready s_value[31:0]  | integer in, one per request
//   m_       | m_valid m_ready m_character    | 1 to 11 characters,
//            | m_last                         | m_last on final one
//
// Each number is loaded, converted by shift-add-3 steps, has its leading digit
// located, and is then written out one character at a time, holding while the
// output register is full and its character is not taken.
// s_ready is high only while idle; the last character may still wait in the
// output register when the next number is accepted.
// Synchronous active-low reset clears the controller and output valid.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_writer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sdaw_pkg::VALUE_W-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sdaw_pkg::CHAR_W-1:0]         m_character,
    output logic                                m_last
);

    sdaw_pkg::sdaw_cmd_t cmd;
    sdaw_pkg::sdaw_sts_t sts;

    sdaw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sdaw_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

// File: tb/signed_decimal_ascii_writer_tb.sv
// ----------------------------------------------------------------------------
// Signed decimal ASCII writer - testbench
// Sends signed integers, predicts each one's decimal text, and checks every
// character and its last flag in order. The run covers directed edge values
// and random values of every digit count, with random idling on both sides
// and one long output hold-off that stalls the input.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_writer_tb;

    import sdaw_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    class decimal_text_tracker;
        text_char_t text_q[$];
        int         errors = 0;

        function void note_number(logic signed [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] mag;
            logic [3:0]         digit[MAX_DIGITS];
            int                 n;
            text_char_t         c;
            mag = value[VALUE_W-1] ? -value : value;
            n = 0;
            do begin
                digit[n] = 4'(mag % 32'd10);
                mag = mag / 32'd10;
                n++;
            end while (mag != 0 && n < MAX_DIGITS);
            if (value[VALUE_W-1]) begin
                c.character = CHAR_MINUS;
                c.last = 1'b0;
                text_q.push_back(c);
            end
            for (int i = n - 1; i >= 0; i--) begin
                c.character = CHAR_ZERO + CHAR_W'(digit[i]);
                c.last = (i == 0);
                text_q.push_back(c);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] character, logic last);
            text_char_t want;
            if (text_q.size() == 0) begin
                $display("%0t: unexpected character %0d last %0b", $time, character, last);
                errors++;
                return;
            end
            want = text_q.pop_front();
            if (character !== want.character) begin
                $display("%0t: character mismatch, expected %0d actual %0d",
                         $time, want.character, character);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch, expected %0b actual %0b",
                         $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return text_q.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic [CHAR_W-1:0]         m_character;
    logic                      m_last;

    decimal_text_tracker tracker = new;
    bit no_idle = 0;
    bit hold_off_pending = 0;

    signed_decimal_ascii_writer uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_number(logic signed [VALUE_W-1:0] value);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        tracker.note_number(value);
    endtask

    // magnitude mostly drawn by digit count; one in four is a raw random word
    function automatic logic signed [VALUE_W-1:0] random_number();
        int unsigned lo;
        int unsigned hi;
        int unsigned mag;
        int          digits;
        if ($urandom_range(3) == 0)
            return $urandom;
        digits = $urandom_range(MAX_DIGITS, 1);
        lo = 1;
        for (int i = 1; i < digits; i++)
            lo = lo * 10;
        hi = (digits == MAX_DIGITS) ? 32'h7FFF_FFFF : lo * 10 - 1;
        if (digits == 1)
            lo = 0;
        mag = $urandom_range(hi, lo);
        return $urandom_range(1) ? -$signed(mag) : $signed(mag);
    endfunction

    // receiver: random idling, plus one long hold-off on request
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 0;
                hold_cnt = 300;
            end
            if (hold_cnt > 0) begin
                m_ready <= 1'b0;
                hold_cnt--;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= 32);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_char(m_character, m_last);
    end

    initial begin
        logic signed [VALUE_W-1:0] directed[$];
        int waited;
        directed = '{0, 1, -1, 7, 9, -9, 10, -10, 99, 100, -100, 999999999,
                     1000000000, -1000000000, 1234567890, -123456789,
                     2147483647, -2147483647, 32'sh8000_0000, 32'sh5555_5555,
                     32'shAAAA_AAAA};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_value = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_number(directed[i]);
        for (int i = 0; i < 150; i++) begin
            no_idle = (i >= 60 && i < 100);
            if (i == 110)
                hold_off_pending = 1;
            send_number(random_number());
        end
        no_idle = 0;
        @(negedge aclk);
        s_valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge aclk);
        waited = 0;
        while (waited < 60) begin
            @(posedge aclk);
            waited++;
        end
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
